// ===== rtl/acpi_pm_register_block_assert.svh =====
// Assertion macros used by the ACPI PM register file (acpipm_regs).
`ifndef ACPI_PM_REGISTER_BLOCK_ASSERT_SVH
`define ACPI_PM_REGISTER_BLOCK_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACPIPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACPIPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/acpipm_pkg.sv =====
// Types and constants for the ACPI PM register block.
`default_nettype none
package acpipm_pkg;

  localparam int TMR_W       = 24;
  localparam int OVF_EN_BIT  = 16;
  localparam int SLP_EN_BIT  = 13;
  localparam int SLP_TYP_HI  = 12;
  localparam int SLP_TYP_LO  = 10;

  localparam logic [TMR_W-1:0] TMR_MAX     = 24'hFF_FFFF;
  localparam logic [2:0]       SLP_TYP_OK  = 3'd5;
  localparam logic [31:0]      CTRL_RST    = 32'h0000_0001;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    WORD_STS_EN = 4'd0,
    WORD_CTRL   = 4'd1,
    WORD_TMR    = 4'd2
  } word_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] offset;
    logic [7:0] write_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        fault;
    logic        sci_level;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/acpipm_regs.sv =====
// PM1 status/enable, PM1 control and PM timer registers with their update logic.
`default_nettype none
`include "acpi_pm_register_block_assert.svh"
module acpipm_regs (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      step,
  input  wire                      acpi_enable,
  input  wire acpipm_pkg::item_t   item,
  output acpipm_pkg::result_t      res
);

  logic [31:0]                  se_r, se_nxt;
  logic [31:0]                  ctrl_r, ctrl_nxt;
  logic [acpipm_pkg::TMR_W-1:0] tmr_r, tmr_nxt;
  logic [4:0]                   shamt;
  logic [31:0]                  byte_sh;
  logic [31:0]                  byte_mask;
  logic [31:0]                  ctrl_wr;
  acpipm_pkg::word_t            word;

  assign shamt     = {item.offset[1:0], 3'b000};
  assign byte_sh   = {24'h00_0000, item.write_byte} << shamt;
  assign byte_mask = 32'h0000_00FF << shamt;
  assign ctrl_wr   = (ctrl_r & ~byte_mask) | byte_sh;
  assign word      = acpipm_pkg::word_t'(item.offset[5:2]);

  always_comb begin
    se_nxt        = se_r;
    ctrl_nxt      = ctrl_r;
    tmr_nxt       = tmr_r;
    res.read_data = 32'h0000_0000;
    res.fault     = 1'b0;
    case (item.kind)
      acpipm_pkg::KIND_TICK: begin
        if (acpi_enable) begin
          tmr_nxt = tmr_r + 24'd1;
          if (tmr_r == acpipm_pkg::TMR_MAX) begin
            se_nxt[0] = 1'b1;
          end
        end
      end
      acpipm_pkg::KIND_READ: begin
        case (word)
          acpipm_pkg::WORD_STS_EN: res.read_data = se_r >> shamt;
          acpipm_pkg::WORD_CTRL:   res.read_data = ctrl_r >> shamt;
          acpipm_pkg::WORD_TMR:    res.read_data = {8'h00, tmr_r} >> shamt;
          default:                 res.fault = 1'b1;
        endcase
      end
      acpipm_pkg::KIND_WRITE: begin
        case (word)
          acpipm_pkg::WORD_STS_EN: begin
            // status bytes are write-one-to-clear, enable bytes are replaced
            if (!item.offset[1]) begin
              se_nxt = se_r & ~byte_sh;
            end else begin
              se_nxt = (se_r & ~byte_mask) | byte_sh;
            end
          end
          acpipm_pkg::WORD_CTRL: begin
            ctrl_nxt = ctrl_wr;
            if (ctrl_wr[acpipm_pkg::SLP_EN_BIT]) begin
              if (ctrl_wr[acpipm_pkg::SLP_TYP_HI:acpipm_pkg::SLP_TYP_LO]
                  == acpipm_pkg::SLP_TYP_OK) begin
                ctrl_nxt[acpipm_pkg::SLP_EN_BIT] = 1'b0;
              end else begin
                res.fault = 1'b1;
              end
            end
          end
          default: res.fault = 1'b1;
        endcase
      end
      default: ;
    endcase
    res.sci_level = se_nxt[0] & se_nxt[acpipm_pkg::OVF_EN_BIT] & acpi_enable;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_r   <= 32'h0000_0000;
      ctrl_r <= acpipm_pkg::CTRL_RST;
      tmr_r  <= '0;
    end else if (step) begin
      se_r   <= se_nxt;
      ctrl_r <= ctrl_nxt;
      tmr_r  <= tmr_nxt;
    end
  end

  `ACPIPM_ASSERT_NOW(a_sci_gated, clk, rst_n, !acpi_enable, !res.sci_level, "sci while disabled")
  `ACPIPM_ASSERT_NEXT(a_tick_incr, clk, rst_n,
    step && item.kind == acpipm_pkg::KIND_TICK && acpi_enable,
    tmr_r == $past(tmr_r) + 24'd1, "timer did not advance on tick")
  `ACPIPM_ASSERT_NEXT(a_read_pure, clk, rst_n, step && item.kind == acpipm_pkg::KIND_READ,
    $stable(se_r) && $stable(ctrl_r) && $stable(tmr_r), "read changed state")
  `ACPIPM_ASSERT_NEXT(a_idle_hold, clk, rst_n, !step,
    $stable(se_r) && $stable(ctrl_r) && $stable(tmr_r), "state changed without transfer")

endmodule
`default_nettype wire

// ===== rtl/acpi_pm_register_block.sv =====
// Top level of the ACPI PM1 register block with PM timer.
// Takes one item (timer tick, byte read or byte write) per clock and returns one result
// per item. An item is held in the input register; the register update and read
// mux sit between it and the result register, and the block sustains one item per cycle
// while out_tready stays high.
// in_tready falls only when both the input and the result register hold items. The
// acpi_enable register (cfg port, reset 1) gates timer ticks and the SCI level.
`default_nettype none
module acpi_pm_register_block (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [5:0] offset, [13:6] write_byte, [15:14] zero
  input  wire  [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_data, [32] sci_level, [39:33] zero
  output logic        out_tuser,  // [0] fault
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_data    // [0] acpi_enable
);

  logic                s1_valid_r, s1_valid_nxt;
  acpipm_pkg::item_t   s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  acpipm_pkg::result_t out_res_r;
  acpipm_pkg::result_t res;
  logic                acpi_en_r;
  logic                advance;
  logic                step;

  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt  = (in_tvalid && in_tready) || (s1_valid_r && !advance);
  assign out_valid_nxt = step || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acpi_en_r   <= 1'b1;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        acpi_en_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.kind       <= acpipm_pkg::kind_t'(in_tuser);
      s1_item_r.offset     <= in_tdata[5:0];
      s1_item_r.write_byte <= in_tdata[13:6];
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  acpipm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .acpi_enable (acpi_en_r),
    .item        (s1_item_r),
    .res         (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b000_0000, out_res_r.sci_level, out_res_r.read_data};
  assign out_tuser  = out_res_r.fault;

endmodule
`default_nettype wire

// ===== tb/sv/acpi_pm_register_block_test.sv =====
// Self-checking testbench for the ACPI PM1 register block with its 24-bit PM timer.
module acpi_pm_register_block_test;
  import acpipm_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  // shadow copy of the register file
  logic [31:0]      shadow_sts_en;
  logic [31:0]      shadow_ctrl;
  logic [TMR_W-1:0] shadow_timer;
  logic             shadow_acpi_en;

  result_t pending_responses[$];
  int      errors = 0;
  int      checked = 0;
  int      quiet = 0;
  bit      source_gaps = 1'b1;
  bit      sink_gaps = 1'b1;
  logic    hold_sink = 1'b0;

  acpi_pm_register_block dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t apply_pm_access(input logic [1:0] kind, input logic [5:0] off,
                                               input logic [7:0] wb);
    result_t    r;
    logic [4:0] sh;
    logic [3:0] word;
    logic [31:0] lane;
    logic [31:0] lane_mask;
    r = '0;
    sh = {off[1:0], 3'b000};
    word = off[5:2];
    lane = {24'd0, wb} << sh;
    lane_mask = 32'h0000_00FF << sh;
    case (kind)
      KIND_TICK: begin
        if (shadow_acpi_en) begin
          shadow_timer = shadow_timer + 1'b1;
          if (shadow_timer == '0) shadow_sts_en[0] = 1'b1;
        end
      end
      KIND_READ: begin
        case (word)
          WORD_STS_EN: r.read_data = shadow_sts_en >> sh;
          WORD_CTRL:   r.read_data = shadow_ctrl >> sh;
          WORD_TMR:    r.read_data = {8'd0, shadow_timer} >> sh;
          default:     r.fault = 1'b1;
        endcase
      end
      KIND_WRITE: begin
        case (word)
          WORD_STS_EN: begin
            if (!off[1]) shadow_sts_en = shadow_sts_en & ~lane;   // write-one-to-clear
            else shadow_sts_en = (shadow_sts_en & ~lane_mask) | lane;
          end
          WORD_CTRL: begin
            shadow_ctrl = (shadow_ctrl & ~lane_mask) | lane;
            if (shadow_ctrl[SLP_EN_BIT]) begin
              if (shadow_ctrl[SLP_TYP_HI:SLP_TYP_LO] == SLP_TYP_OK) shadow_ctrl[SLP_EN_BIT] = 1'b0;
              else r.fault = 1'b1;
            end
          end
          default: r.fault = 1'b1;
        endcase
      end
      default: ;
    endcase
    r.sci_level = shadow_acpi_en & shadow_sts_en[0] & shadow_sts_en[OVF_EN_BIT];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on response %0d, %s: got %h, expected %h", checked, field, got, want);
    errors++;
  endtask

  task automatic send_access(input logic [1:0] kind, input logic [5:0] off, input logic [7:0] wb);
    while (source_gaps && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, wb, off};
    do @(posedge clk); while (!in_tready);
    pending_responses.push_back(apply_pm_access(kind, off, wb));
  endtask

  task automatic send_random_access();
    int          pick;
    logic [1:0]  kind;
    logic [5:0]  off;
    pick = $urandom_range(99);
    if (pick < 40) kind = KIND_TICK;
    else if (pick < 65) kind = KIND_READ;
    else if (pick < 95) kind = KIND_WRITE;
    else kind = KIND_UNUSED;
    if ($urandom_range(99) < 90) off = {4'($urandom_range(2)), 2'($urandom_range(3))};
    else off = 6'($urandom_range(63));
    send_access(kind, off, 8'($urandom));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_acpi_enable(input logic value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_acpi_en = value;
  endtask

  task automatic test_directed_registers();
    send_access(KIND_READ, 6'd0, 8'h00);
    send_access(KIND_READ, 6'd4, 8'h00);
    send_access(KIND_TICK, 6'd0, 8'h00);
    send_access(KIND_TICK, 6'd63, 8'hFF);
    send_access(KIND_READ, 6'd8, 8'h00);
    send_access(KIND_READ, 6'd11, 8'h00);
    // enable bytes replace, status bytes clear
    send_access(KIND_WRITE, 6'd2, 8'hFF);
    send_access(KIND_WRITE, 6'd3, 8'hFF);
    send_access(KIND_READ, 6'd0, 8'h00);
    send_access(KIND_READ, 6'd3, 8'h00);
    send_access(KIND_WRITE, 6'd0, 8'hFF);
    send_access(KIND_WRITE, 6'd1, 8'hFF);
    // sleep enable with the supported type, then with an unsupported one
    send_access(KIND_WRITE, 6'd5, 8'h34);
    send_access(KIND_WRITE, 6'd5, 8'h20);
    send_access(KIND_READ, 6'd4, 8'h00);
    // timer is read-only, upper words unmapped
    send_access(KIND_WRITE, 6'd8, 8'hA5);
    send_access(KIND_WRITE, 6'd63, 8'h00);
    send_access(KIND_READ, 6'd12, 8'h00);
    send_access(KIND_READ, 6'd63, 8'h00);
    send_access(KIND_UNUSED, 6'd0, 8'hFF);
    send_access(KIND_WRITE, 6'd4, 8'h00);
    send_access(KIND_WRITE, 6'd7, 8'hFF);
    send_access(KIND_READ, 6'd6, 8'h00);
  endtask

  task automatic test_enable_gating();
    write_acpi_enable(1'b0);
    repeat (6) send_access(KIND_TICK, 6'($urandom_range(63)), 8'($urandom));
    send_access(KIND_READ, 6'd8, 8'h00);
    send_access(KIND_WRITE, 6'd2, 8'h01);
    send_access(KIND_READ, 6'd0, 8'h00);
    write_acpi_enable(1'b1);
    repeat (3) send_access(KIND_TICK, 6'd0, 8'h00);
    send_access(KIND_READ, 6'd9, 8'h00);
  endtask

  task automatic test_backpressure();
    settle();
    source_gaps = 1'b0;
    fork
      begin
        hold_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink <= 1'b0;
      end
    join_none
    repeat (30) send_random_access();
    source_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 4; phase++) begin
      if (phase == 0) write_acpi_enable(1'b1);
      else if (phase == 1) write_acpi_enable(1'b0);
      else write_acpi_enable(1'($urandom_range(1)));
      source_gaps = (phase != 2);
      sink_gaps   = (phase != 2);
      repeat (95) send_random_access();
    end
    source_gaps = 1'b1;
    sink_gaps   = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[31:0], 32'd0);
      end else begin
        result_t want;
        want = pending_responses.pop_front();
        if (out_tdata[31:0] !== want.read_data)
          report_mismatch("read_data", out_tdata[31:0], want.read_data);
        if (out_tuser !== want.fault)
          report_mismatch("fault", {31'd0, out_tuser}, {31'd0, want.fault});
        if (out_tdata[32] !== want.sci_level)
          report_mismatch("sci_level", {31'd0, out_tdata[32]}, {31'd0, want.sci_level});
      end
      checked++;
    end
    out_tready <= !hold_sink && (!sink_gaps || $urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d responses pending", quiet,
               pending_responses.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    shadow_sts_en  = '0;
    shadow_ctrl    = CTRL_RST;
    shadow_timer   = '0;
    shadow_acpi_en = 1'b1;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_registers();
    test_enable_gating();
    test_backpressure();
    test_random_traffic();
    settle();
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
